// ===== sv/sms_user_data_decoder_defines.svh =====
// Assertion macros shared by the SMS user-data decoder checker.
`ifndef SMS_USER_DATA_DECODER_DEFINES_SVH
`define SMS_USER_DATA_DECODER_DEFINES_SVH

// Clocked assertion, quiet while reset is high.
`define SMSUD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define SMSUD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/smsud_pkg.sv =====
// Shared types, codes and helpers for the SMS user-data decoder.
package smsud_pkg;

  localparam int GroupDepth = 3;

  typedef enum logic [1:0] {
    MODE_GSM7  = 2'd0,
    MODE_8BIT  = 2'd1,
    MODE_UCS2  = 2'd2,
    MODE_SPARE = 2'd3
  } coding_mode_t;

  typedef struct packed {
    logic [1:0]                 count;
    logic [GroupDepth-1:0][7:0] bytes;
    logic [GroupDepth-1:0]      eom;
  } smsud_group_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
    end
    return v;
  endfunction

endpackage

// ===== sv/sms_user_data_decoder.sv =====
// Top level of the SMS user-data decoder: input register, decode, result register.
//
//  channel   handshake             payload
//  input     in_valid / in_ready   hex_char[7:0], last_char
//  output    out_valid / out_ready out_byte[7:0], end_of_message, run_last
//  config    cfg_wr_en             cfg_wr_data[1:0] (coding_mode)
//
// A character waits in the input register, then decodes in one pass into a group
// of up to three results, which leave one per cycle while out_ready is high.
// The input register can take the next character while the result register drains.
// Reset is synchronous and clears the decode state, mode and both registers.
// A stalled output holds the group; the input register then holds one character.
module sms_user_data_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] hex_char,
  input  logic       last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       end_of_message,
  output logic       run_last
);
  import smsud_pkg::*;

  logic [1:0]   coding_mode;
  logic         char_valid;
  logic [7:0]   char_q;
  logic         last_q;
  logic         can_load;
  logic         advance;
  smsud_group_t group;

  assign advance  = char_valid && can_load;
  assign in_ready = !char_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode <= MODE_GSM7;
    end else if (cfg_wr_en) begin
      coding_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      char_valid <= 1'b1;
    end else if (advance) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_q <= hex_char;
      last_q <= last_char;
    end
  end

  smsud_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .coding_mode (coding_mode),
    .hex_char    (char_q),
    .last_char   (last_q),
    .group       (group)
  );

  smsud_out_queue u_out_queue (
    .clk            (clk),
    .rst            (rst),
    .load           (advance),
    .group_in       (group),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .end_of_message (end_of_message),
    .run_last       (run_last)
  );

endmodule

// ===== sv/smsud_decode.sv =====
// Decode state and single-pass decode of one character into a result group.
module smsud_decode (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic [1:0]            coding_mode,
  input  logic [7:0]            hex_char,
  input  logic                  last_char,
  output smsud_pkg::smsud_group_t group
);
  import smsud_pkg::*;

  logic [3:0] nibble_hold, nibble_hold_next;
  logic       nibble_valid, nibble_valid_next;
  logic [7:0] high_byte_hold, high_byte_hold_next;
  logic       high_byte_valid, high_byte_valid_next;
  logic [2:0] septet_position, septet_position_next;
  logic [6:0] carry_bits, carry_bits_next;

  logic [7:0] byte_val;
  logic [2:0] n;
  logic [7:0] mask;
  logic [7:0] septet;
  logic [6:0] carry_new;
  logic [1:0] cnt;

  always_comb begin
    byte_val  = {nibble_hold, hex_value(hex_char)};
    n         = (septet_position > 3'd6) ? 3'd0 : septet_position;
    mask      = 8'h7f >> n;
    septet    = 8'((byte_val & mask) << n) + {1'b0, carry_bits};
    carry_new = 7'((byte_val & ~mask) >> (3'd7 - n));
  end

  always_comb begin
    nibble_hold_next     = nibble_hold;
    nibble_valid_next    = nibble_valid;
    high_byte_hold_next  = high_byte_hold;
    high_byte_valid_next = high_byte_valid;
    septet_position_next = septet_position;
    carry_bits_next      = carry_bits;
    group                = '0;
    cnt                  = 2'd0;

    if (!nibble_valid) begin
      nibble_hold_next  = hex_value(hex_char);
      nibble_valid_next = 1'b1;
    end else begin
      nibble_hold_next  = 4'd0;
      nibble_valid_next = 1'b0;
      unique case (coding_mode_t'(coding_mode))
        MODE_GSM7: begin
          group.bytes[cnt] = septet;
          cnt              = cnt + 2'd1;
          if (n == 3'd6) begin
            group.bytes[cnt]     = {1'b0, carry_new};
            cnt                  = cnt + 2'd1;
            carry_bits_next      = 7'd0;
            septet_position_next = 3'd0;
          end else begin
            carry_bits_next      = carry_new;
            septet_position_next = n + 3'd1;
          end
        end
        MODE_UCS2: begin
          if (!high_byte_valid) begin
            high_byte_hold_next  = byte_val;
            high_byte_valid_next = 1'b1;
          end else begin
            if (high_byte_hold != 8'd0) begin
              group.bytes[cnt] = high_byte_hold;
              cnt              = cnt + 2'd1;
            end
            group.bytes[cnt]     = byte_val;
            cnt                  = cnt + 2'd1;
            high_byte_hold_next  = 8'd0;
            high_byte_valid_next = 1'b0;
          end
        end
        MODE_8BIT, MODE_SPARE: begin
          group.bytes[cnt] = byte_val;
          cnt              = cnt + 2'd1;
        end
      endcase
    end

    if (last_char) begin
      group.bytes[cnt]     = 8'd0;
      group.eom[cnt]       = 1'b1;
      cnt                  = cnt + 2'd1;
      nibble_hold_next     = 4'd0;
      nibble_valid_next    = 1'b0;
      high_byte_hold_next  = 8'd0;
      high_byte_valid_next = 1'b0;
      septet_position_next = 3'd0;
      carry_bits_next      = 7'd0;
    end
    group.count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_hold     <= 4'd0;
      nibble_valid    <= 1'b0;
      high_byte_hold  <= 8'd0;
      high_byte_valid <= 1'b0;
      septet_position <= 3'd0;
      carry_bits      <= 7'd0;
    end else if (advance) begin
      nibble_hold     <= nibble_hold_next;
      nibble_valid    <= nibble_valid_next;
      high_byte_hold  <= high_byte_hold_next;
      high_byte_valid <= high_byte_valid_next;
      septet_position <= septet_position_next;
      carry_bits      <= carry_bits_next;
    end
  end

endmodule

// ===== sv/smsud_out_queue.sv =====
// Result register holding one decoded group, shifted out one result per cycle while out_ready is high.
module smsud_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  smsud_pkg::smsud_group_t group_in,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   end_of_message,
  output logic                   run_last
);
  import smsud_pkg::*;

  smsud_group_t group;
  logic [1:0]   idx;
  logic [1:0]   count;
  logic         take;
  logic         last_take;

  assign count          = group.count;
  assign out_valid      = (count != 2'd0);
  assign run_last       = (idx == count - 2'd1);
  assign out_byte       = group.bytes[idx];
  assign end_of_message = group.eom[idx];
  assign take           = out_valid && out_ready;
  assign last_take      = take && run_last;
  assign can_load       = !out_valid || last_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      group.count <= 2'd0;
      idx         <= 2'd0;
    end else if (load) begin
      group <= group_in;
      idx   <= 2'd0;
    end else if (last_take) begin
      group.count <= 2'd0;
      idx         <= 2'd0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule

// ===== sv/sms_user_data_decoder_checker.sv =====
// Port-level checker for the SMS user-data decoder, bound to the top level.
`include "sms_user_data_decoder_defines.svh"

module sms_user_data_decoder_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_wr_en,
  input logic [1:0] cfg_wr_data,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] hex_char,
  input logic       last_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       end_of_message,
  input logic       run_last
);

  `SMSUD_ASSERT(a_eom_zero, out_valid && end_of_message |-> out_byte == 8'd0, "terminator not zero")
  `SMSUD_ASSERT(a_eom_last, out_valid && end_of_message |-> run_last, "terminator not last result")
  `SMSUD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last), "stalled result changed")
  `SMSUD_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind sms_user_data_decoder sms_user_data_decoder_checker u_checker (.*);

// ===== dv/tb_sms_user_data_decoder.sv =====
// Self-checking testbench for the SMS user-data decoder: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_sms_user_data_decoder;
  import smsud_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int NUM_ROWS      = 27;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 35;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       eom;
    logic       run_last;
  } decoded_t;

  typedef struct packed {
    logic         do_cfg;
    coding_mode_t mode;
    logic [7:0]   ch;
    logic         last;
    logic         typed;
    logic [7:0]   exp_byte;
    logic         exp_eom;
  } char_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] hex_char = 8'd0;
  logic       last_char = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] out_byte;
  logic       end_of_message;
  logic       run_last;

  coding_mode_t cur_mode = MODE_GSM7;
  logic [3:0]   nib_hold = 4'd0;
  logic         nib_valid = 1'b0;
  logic [7:0]   hi_hold = 8'd0;
  logic         hi_valid = 1'b0;
  logic [2:0]   sept_pos = 3'd0;
  logic [6:0]   carry = 7'd0;

  decoded_t    step_out [3];
  int          step_cnt;
  decoded_t    expected_bytes [$];
  char_row_t   plan [NUM_ROWS];
  bit          quiet = 1'b0;
  int          stall_left = 0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned chars_sent = 0;
  int unsigned cycles = 0;

  sms_user_data_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .hex_char       (hex_char),
    .last_char      (last_char),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .end_of_message (end_of_message),
    .run_last       (run_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 14);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: byte=%h eom=%b run_last=%b",
                   out_byte, end_of_message, run_last);
      end else begin
        want = expected_bytes.pop_front();
        if (want.out_byte !== out_byte || want.eom !== end_of_message ||
            want.run_last !== run_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte=%h eom=%b run_last=%b, got byte=%h eom=%b run_last=%b",
                     want.out_byte, want.eom, want.run_last,
                     out_byte, end_of_message, run_last);
        end
      end
    end
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  task automatic emit(input logic [7:0] b, input logic e);
    step_out[step_cnt] = '{out_byte: b, eom: e, run_last: 1'b0};
    step_cnt++;
  endtask

  task automatic decode_char(input logic [7:0] ch, input logic last);
    logic [3:0] nib;
    logic [7:0] b;
    int n;
    int mask;
    int v;
    step_cnt = 0;
    nib = nibble_of(ch);
    if (!nib_valid) begin
      nib_hold  = nib;
      nib_valid = 1'b1;
    end else begin
      b = {nib_hold, nib};
      nib_hold  = 4'd0;
      nib_valid = 1'b0;
      if (cur_mode == MODE_GSM7) begin
        n = (sept_pos > 6) ? 0 : int'(sept_pos);
        mask = 'h7f >> n;
        v = ((int'(b) & mask) << n) + int'(carry);
        emit(v[7:0], 1'b0);
        carry = 7'((int'(b) & (255 - mask)) >> (7 - n));
        if (n == 6) begin
          emit({1'b0, carry}, 1'b0);
          carry    = 7'd0;
          sept_pos = 3'd0;
        end else begin
          sept_pos = 3'(n + 1);
        end
      end else if (cur_mode == MODE_UCS2) begin
        if (!hi_valid) begin
          hi_hold  = b;
          hi_valid = 1'b1;
        end else begin
          if (hi_hold != 8'd0) emit(hi_hold, 1'b0);
          emit(b, 1'b0);
          hi_hold  = 8'd0;
          hi_valid = 1'b0;
        end
      end else begin
        emit(b, 1'b0);
      end
    end
    if (last) begin
      emit(8'd0, 1'b1);
      nib_hold  = 4'd0;
      nib_valid = 1'b0;
      hi_hold   = 8'd0;
      hi_valid  = 1'b0;
      sept_pos  = 3'd0;
      carry     = 7'd0;
    end
    if (step_cnt > 0) step_out[step_cnt - 1].run_last = 1'b1;
  endtask

  task automatic write_mode(input coding_mode_t m);
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = m;
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last, input logic typed,
                           input logic [7:0] exp_byte, input logic exp_eom);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    hex_char  <= ch;
    last_char <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    decode_char(ch, last);
    if (typed) begin
      expected_bytes.push_back('{out_byte: exp_byte, eom: exp_eom, run_last: 1'b1});
    end else begin
      for (int j = 0; j < step_cnt; j++) expected_bytes.push_back(step_out[j]);
    end
  endtask

  initial begin
    coding_mode_t phase_modes [NUM_PHASES];
    logic [7:0] ch;
    int k;

    plan = '{
      '{1'b0, MODE_GSM7, "4",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "1",   1'b0, 1'b1, 8'h41, 1'b0},
      '{1'b0, MODE_GSM7, 8'hff, 1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "F",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "F",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "f",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "f",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "A",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "a",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "9",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "0",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "F",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "f",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "B",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "c",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "E",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_GSM7, "D",   1'b1, 1'b0, 8'h00, 1'b0},
      '{1'b1, MODE_8BIT, "F",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_8BIT, "F",   1'b0, 1'b1, 8'hff, 1'b0},
      '{1'b1, MODE_UCS2, "0",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_UCS2, "0",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_UCS2, "4",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_UCS2, "1",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_UCS2, "1",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_UCS2, "2",   1'b0, 1'b0, 8'h00, 1'b0},
      '{1'b0, MODE_UCS2, "3",   1'b1, 1'b1, 8'h00, 1'b1}
    };
    phase_modes = '{MODE_8BIT, MODE_GSM7, MODE_UCS2, MODE_SPARE,
                    MODE_GSM7, MODE_UCS2, MODE_8BIT, MODE_GSM7};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (plan[i].do_cfg) write_mode(plan[i].mode);
      send_char(plan[i].ch, plan[i].last, plan[i].typed, plan[i].exp_byte, plan[i].exp_eom);
    end

    // phases may end mid-message, so a mode switch lands on held state
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_mode(phase_modes[p]);
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          ch = 8'($urandom_range(0, 255));
        end else begin
          k = $urandom_range(0, 21);
          if (k < 10) ch = 8'("0" + k);
          else if (k < 16) ch = 8'("A" + k - 10);
          else ch = 8'("a" + k - 16);
        end
        send_char(ch, ($urandom_range(0, 13) == 0), 1'b0, 8'h00, 1'b0);
      end
    end

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d characters and %0d checked results in all four coding modes",
             chars_sent, results_seen);
    $display("failures counted: %0d", errors);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/smsud_pkg.sv
sv/smsud_decode.sv
sv/smsud_out_queue.sv
sv/sms_user_data_decoder.sv
sv/sms_user_data_decoder_checker.sv
dv/tb_sms_user_data_decoder.sv
